// ===== src/drt_pkg.sv =====
package drt_pkg;

   localparam int MAX_RECTS   = 32;
   localparam int COORD_BITS  = 13;
   localparam int NEAR_DIST   = 8;
   localparam int AREA_FACTOR = 2;

   // Stored coordinates run from 0 to 1 << COORD_BITS inclusive.
   localparam int CW        = COORD_BITS + 1;
   localparam int AW        = 2 * CW + 1;
   localparam int SURF_LIM  = 1 << COORD_BITS;
   localparam int STEP_W    = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int CNT_W     = $clog2(MAX_RECTS + 1);
   localparam int IDX_IN_W  = 6;
   localparam int CMP_W     = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;
   localparam int CFG_W     = 14;
   localparam int OUT_W     = 14;
   localparam int OCNT_W    = 6;
   localparam int IN_W      = 16;

   typedef enum logic [2:0] {
      CMD_ADD   = 3'd0,
      CMD_FULL  = 3'd1,
      CMD_RESET = 3'd2,
      CMD_READ  = 3'd3,
      CMD_BBOX  = 3'd4
   } cmd_type;

   localparam logic REG_SURF_W = 1'b0;
   localparam logic REG_SURF_H = 1'b1;

   typedef struct packed {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic [CW-1:0] w;
      logic [CW-1:0] h;
   } rect_type;

   typedef struct packed {
      logic                  hit;
      logic                  fits;
      rect_type              joined;
   } head_result_type;

   typedef struct packed {
      logic [2:0]            command;
      logic signed [IN_W-1:0] rect_x;
      logic signed [IN_W-1:0] rect_y;
      logic signed [IN_W-1:0] rect_w;
      logic signed [IN_W-1:0] rect_h;
      logic [IDX_IN_W-1:0]   entry_index;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0]      out_x;
      logic [OUT_W-1:0]      out_y;
      logic [OUT_W-1:0]      out_w;
      logic [OUT_W-1:0]      out_h;
      logic                  entry_valid;
      logic [OCNT_W-1:0]     region_count;
      logic                  region_full;
      logic                  region_empty;
   } rsp_type;

endpackage

// ===== src/damage_rect_tracker.sv =====
// Channel   | Direction | Handshake          | Payload
// req_      | in        | req_valid/stall    | command, rectangle, entry index
// rsp_      | out       | rsp_valid/stall    | rectangle, entry valid, status
// csr_      | in        | csr_valid/ready    | register index, write data
//
// An add that survives the clamp passes through clamp, area, one ring step per table entry
// and the result load; an add clamped away goes from the clamp straight to the result load.
// A read, and a bounding box outside full-screen mode, step the whole ring before the load.
// All other commands, adds in full-screen mode included, go straight to the result load.
// Reset is synchronous and empties the table at once. A new request is taken while
// a finished result still waits on rsp_stall.
module damage_rect_tracker
   import drt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [CFG_W-1:0] csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_AREA,
      ST_SCAN,
      ST_DONE
   } state_type;

   localparam int SW = IN_W + 2;

   state_type         state_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              full_ff;
   logic [CFG_W-1:0]  surf_w_ff, surf_h_ff;
   req_type           req_ff;
   rect_type          newc_ff;
   logic [AW-1:0]     twice_ff;
   rect_type          res_ff;
   logic              evalid_ff;
   logic              merged_ff;
   logic [STEP_W-1:0] step_ff;

   // Surface limits, saturated to the coordinate range.
   logic [CW-1:0] surf_w_dim, surf_h_dim;

   always_comb begin
      surf_w_dim = (int'(surf_w_ff) > SURF_LIM) ? CW'(SURF_LIM) : CW'(surf_w_ff);
      surf_h_dim = (int'(surf_h_ff) > SURF_LIM) ? CW'(SURF_LIM) : CW'(surf_h_ff);
   end

   // Configuration writes land at once; the port never holds off a transfer.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         surf_w_ff <= CFG_W'(1920);
         surf_h_ff <= CFG_W'(1080);
      end else if (csr_valid) begin
         case (csr_index)
            REG_SURF_W: surf_w_ff <= csr_data;
            REG_SURF_H: surf_h_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Clamp of the added rectangle to the surface. Every term is widened to
   // SW signed bits so that no sum can wrap.
   logic signed [SW-1:0] cx0, cy0, cw0, ch0;
   logic signed [SW-1:0] cx1, cy1, cw1, ch1;
   logic signed [SW-1:0] cw2, ch2;
   logic signed [SW-1:0] sw_s, sh_s;
   logic                 clamp_ok;
   rect_type             clipped_box;

   always_comb begin
      cx0  = SW'(req_ff.rect_x);
      cy0  = SW'(req_ff.rect_y);
      cw0  = SW'(req_ff.rect_w);
      ch0  = SW'(req_ff.rect_h);
      sw_s = $signed({{(SW-CW){1'b0}}, surf_w_dim});
      sh_s = $signed({{(SW-CW){1'b0}}, surf_h_dim});

      cx1 = (cx0 < 0) ? '0 : cx0;
      cw1 = (cx0 < 0) ? (cw0 + cx0) : cw0;
      cy1 = (cy0 < 0) ? '0 : cy0;
      ch1 = (cy0 < 0) ? (ch0 + cy0) : ch0;

      cw2 = ((cx1 + cw1) > sw_s) ? (sw_s - cx1) : cw1;
      ch2 = ((cy1 + ch1) > sh_s) ? (sh_s - cy1) : ch1;

      clamp_ok      = (cw2 > 0) && (ch2 > 0);
      clipped_box.x = CW'(cx1);
      clipped_box.y = CW'(cy1);
      clipped_box.w = CW'(cw2);
      clipped_box.h = CW'(ch2);
   end

   // The table is a ring of cells. Cell 0 sits at the merge unit; during a
   // scan every cell takes its upper neighbor, and the last cell takes what
   // the merge unit hands back. After MAX_RECTS steps each entry is home again.
   rect_type        cells [MAX_RECTS];
   rect_type        head;
   rect_type        tail_in;
   rect_type        head_other;
   head_result_type head_res;
   logic            shift_en;
   logic            is_add, is_read, active, merge_now, append_now, last_step;
   logic [CMP_W-1:0] step_c, count_c, index_c;

   assign head     = cells[0];
   assign shift_en = (state_ff == ST_SCAN);

   for (genvar i = 0; i < MAX_RECTS; i++) begin : g_ring
      rect_type nb;
      if (i == MAX_RECTS - 1) begin : g_tail
         assign nb = tail_in;
      end else begin : g_mid
         assign nb = cells[i+1];
      end
      drt_cell u_cell (
         .clock     (clock),
         .shift_en  (shift_en),
         .shift_in  (nb),
         .entry_out (cells[i])
      );
   end

   drt_head u_head (
      .entry      (head),
      .other      (head_other),
      .twice_area (twice_ff),
      .result     (head_res)
   );

   always_comb begin
      is_add     = (req_ff.command == CMD_ADD);
      is_read    = (req_ff.command == CMD_READ);
      step_c     = CMP_W'(step_ff);
      count_c    = CMP_W'(count_ff);
      index_c    = CMP_W'(req_ff.entry_index);
      active     = step_c < count_c;
      last_step  = (step_ff == STEP_W'(MAX_RECTS - 1));
      // An add compares against the new rectangle; a bounding box folds the
      // passing entry into the running union.
      head_other = is_add ? newc_ff : res_ff;
      merge_now  = is_add && active && !merged_ff && head_res.hit && head_res.fits;
      // The cell at the fill level holds nothing yet, so an append simply
      // puts the new rectangle there as it passes.
      append_now = is_add && !merged_ff && (step_c == count_c);
      if (append_now) begin
         tail_in = newc_ff;
      end else if (merge_now) begin
         tail_in = head_res.joined;
      end else begin
         tail_in = head;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         full_ff      <= 1'b0;
         merged_ff    <= 1'b0;
         step_ff      <= '0;
      end else begin
         // In ST_DONE a result that leaves is replaced on the same edge.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff    <= req_data;
                  evalid_ff <= 1'b0;
                  merged_ff <= 1'b0;
                  step_ff   <= '0;
                  // A bounding box in full-screen mode is the whole surface.
                  if (req_data.command == CMD_BBOX && full_ff) begin
                     res_ff <= '{x: '0, y: '0, w: surf_w_dim, h: surf_h_dim};
                  end else begin
                     res_ff <= '0;
                  end
                  case (req_data.command)
                     CMD_ADD: begin
                        state_ff <= full_ff ? ST_DONE : ST_CLAMP;
                     end
                     CMD_FULL: begin
                        full_ff  <= 1'b1;
                        count_ff <= '0;
                        state_ff <= ST_DONE;
                     end
                     CMD_RESET: begin
                        full_ff  <= 1'b0;
                        count_ff <= '0;
                        state_ff <= ST_DONE;
                     end
                     CMD_READ: begin
                        state_ff <= ST_SCAN;
                     end
                     CMD_BBOX: begin
                        state_ff <= full_ff ? ST_DONE : ST_SCAN;
                     end
                     default: begin
                        state_ff <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_CLAMP: begin
               newc_ff  <= clipped_box;
               state_ff <= clamp_ok ? ST_AREA : ST_DONE;
            end
            ST_AREA: begin
               twice_ff <= AW'(AREA_FACTOR) * (AW'(newc_ff.w) * AW'(newc_ff.h));
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               step_ff <= step_ff + 1'b1;
               if (merge_now) begin
                  merged_ff <= 1'b1;
               end
               if (is_read && (step_c == index_c) && (index_c < count_c)) begin
                  res_ff    <= head;
                  evalid_ff <= 1'b1;
               end
               if (req_ff.command == CMD_BBOX && active) begin
                  res_ff <= (step_ff == '0) ? head : head_res.joined;
               end
               if (last_step) begin
                  state_ff <= ST_DONE;
                  if (is_add && !merged_ff && !merge_now) begin
                     if (count_ff >= CNT_W'(MAX_RECTS)) begin
                        full_ff  <= 1'b1;
                        count_ff <= '0;
                     end else begin
                        count_ff <= count_ff + 1'b1;
                     end
                  end
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_data_ff.out_x        <= OUT_W'(res_ff.x);
                  rsp_data_ff.out_y        <= OUT_W'(res_ff.y);
                  rsp_data_ff.out_w        <= OUT_W'(res_ff.w);
                  rsp_data_ff.out_h        <= OUT_W'(res_ff.h);
                  rsp_data_ff.entry_valid  <= evalid_ff;
                  rsp_data_ff.region_count <= OCNT_W'(count_ff);
                  rsp_data_ff.region_full  <= full_ff;
                  rsp_data_ff.region_empty <= !full_ff && (count_ff == '0);
                  rsp_valid_ff             <= 1'b1;
                  state_ff                 <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // Full-screen mode never keeps a rectangle count.
   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (count_ff == '0))
      else $error("rectangle count nonzero in full-screen mode");

   // The fill level never passes the table depth.
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RECTS))
      else $error("rectangle count above table depth");

   // A request transfer always starts work that holds off the next one.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken without entering a busy state");
`endif

endmodule

// ===== src/drt_cell.sv =====
module drt_cell
   import drt_pkg::*;
(
   input  logic     clock,
   input  logic     shift_en,
   input  rect_type shift_in,
   output rect_type entry_out
);

   // One table entry; it takes its neighbor's entry on every ring step.
   rect_type entry_ff;
   rect_type entry_in;

   always_comb begin
      entry_in = shift_en ? shift_in : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

endmodule

// ===== src/drt_head.sv =====
module drt_head
   import drt_pkg::*;
(
   input  rect_type        entry,
   input  rect_type        other,
   input  logic [AW-1:0]   twice_area,
   output head_result_type result
);

   logic [CW:0]   ex2, ey2, ox2, oy2;
   logic [CW:0]   ux2, uy2;
   logic [CW-1:0] ux, uy;
   logic [CW-1:0] dx, dy;
   logic          overlap, near;
   logic [AW-1:0] u_area, e_area;
   rect_type      joined;

   always_comb begin
      ex2 = {1'b0, entry.x} + {1'b0, entry.w};
      ey2 = {1'b0, entry.y} + {1'b0, entry.h};
      ox2 = {1'b0, other.x} + {1'b0, other.w};
      oy2 = {1'b0, other.y} + {1'b0, other.h};

      overlap = ({1'b0, entry.x} < ox2) && (ex2 > {1'b0, other.x}) &&
                ({1'b0, entry.y} < oy2) && (ey2 > {1'b0, other.y});

      dx   = (entry.x >= other.x) ? (entry.x - other.x) : (other.x - entry.x);
      dy   = (entry.y >= other.y) ? (entry.y - other.y) : (other.y - entry.y);
      near = (dx < CW'(NEAR_DIST)) && (dy < CW'(NEAR_DIST));

      ux  = (entry.x < other.x) ? entry.x : other.x;
      uy  = (entry.y < other.y) ? entry.y : other.y;
      ux2 = (ex2 > ox2) ? ex2 : ox2;
      uy2 = (ey2 > oy2) ? ey2 : oy2;

      joined.x = ux;
      joined.y = uy;
      joined.w = CW'(ux2 - {1'b0, ux});
      joined.h = CW'(uy2 - {1'b0, uy});

      u_area = AW'(joined.w) * AW'(joined.h);
      e_area = AW'(entry.w) * AW'(entry.h);

      result.hit    = overlap || near;
      result.fits   = u_area <= (e_area + twice_area);
      result.joined = joined;
   end

endmodule

// ===== tb/sv/tb_damage_rect_tracker.sv =====
module tb_damage_rect_tracker;
   import drt_pkg::*;

   // Command codes that the block does not define. They must leave the state
   // alone and still return one result with the status fields.
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   // Cycles that pass after the last result before the block counts as idle.
   // An add that is dropped or absorbed gives no sign of being done earlier
   // than its result, so this covers the longest command with some margin.
   localparam int SETTLE_CYCLES = MAX_RECTS + 12;
   localparam int RANDOM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 200;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_index;
   logic [CFG_W-1:0] csr_data;

   damage_rect_tracker uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // A directed row carries the request and, where the answer is obvious,
   // the result typed in by hand. Rows without a typed answer are checked
   // against the damage map predictor below.
   typedef struct {
      req_type req;
      bit      typed;
      rsp_type answer;
   } stim_row_type;

   typedef struct {
      bit      typed;
      rsp_type answer;
   } hand_answer_type;

   // Shadow of the damage map: the stored rectangles, their count, the
   // full-screen flag and the two surface registers as last written.
   int               map_x [MAX_RECTS];
   int               map_y [MAX_RECTS];
   int               map_w [MAX_RECTS];
   int               map_h [MAX_RECTS];
   int               map_count;
   bit               map_full;
   logic [CFG_W-1:0] surf_w_reg;
   logic [CFG_W-1:0] surf_h_reg;

   rsp_type         pending_rsp [$];
   hand_answer_type hand_answers [$];

   int error_count;
   int adds_sent;
   int reads_sent;
   int boxes_sent;
   int overflow_count;
   int results_seen;
   bit idle_enable;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int surf_limit(logic [CFG_W-1:0] v);
      return (v > SURF_LIM) ? SURF_LIM : int'(v);
   endfunction

   function automatic int min_of(int a, int b);
      return (a < b) ? a : b;
   endfunction

   function automatic int max_of(int a, int b);
      return (a > b) ? a : b;
   endfunction

   function automatic int dist_of(int a, int b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Clamp the rectangle to the surface, then let the first close or
   // overlapping entry swallow it if the union stays compact enough.
   // Otherwise append it, or fall back to full-screen mode on overflow.
   function automatic void merge_damage(int x, int y, int w, int h);
      int    sw;
      int    sh;
      int    ux;
      int    uy;
      int    ux2;
      int    uy2;
      longint union_area;
      bit    touches;
      sw = surf_limit(surf_w_reg);
      sh = surf_limit(surf_h_reg);
      if (map_full) return;
      if (x < 0) begin
         w = w + x;
         x = 0;
      end
      if (y < 0) begin
         h = h + y;
         y = 0;
      end
      if (x + w > sw) w = sw - x;
      if (y + h > sh) h = sh - y;
      if (w <= 0 || h <= 0) return;
      for (int i = 0; i < map_count; i++) begin
         touches = (map_x[i] < x + w && map_x[i] + map_w[i] > x &&
                    map_y[i] < y + h && map_y[i] + map_h[i] > y) ||
                   (dist_of(map_x[i], x) < NEAR_DIST && dist_of(map_y[i], y) < NEAR_DIST);
         if (touches) begin
            ux  = min_of(map_x[i], x);
            uy  = min_of(map_y[i], y);
            ux2 = max_of(map_x[i] + map_w[i], x + w);
            uy2 = max_of(map_y[i] + map_h[i], y + h);
            union_area = longint'(ux2 - ux) * longint'(uy2 - uy);
            if (union_area <= longint'(map_w[i]) * longint'(map_h[i]) +
                              longint'(w) * longint'(h) * AREA_FACTOR) begin
               map_x[i] = ux;
               map_y[i] = uy;
               map_w[i] = ux2 - ux;
               map_h[i] = uy2 - uy;
               return;
            end
         end
      end
      if (map_count >= MAX_RECTS) begin
         map_full  = 1'b1;
         map_count = 0;
         overflow_count++;
         return;
      end
      map_x[map_count] = x;
      map_y[map_count] = y;
      map_w[map_count] = w;
      map_h[map_count] = h;
      map_count++;
   endfunction

   // Applies one request to the shadow map and returns the result it owes.
   function automatic rsp_type damage_result(req_type r);
      rsp_type o;
      int      bx;
      int      by;
      int      bw;
      int      bh;
      int      x2;
      int      y2;
      bit      hit;
      bx = 0;
      by = 0;
      bw = 0;
      bh = 0;
      hit = 1'b0;
      case (r.command)
         CMD_ADD: begin
            merge_damage(int'(r.rect_x), int'(r.rect_y), int'(r.rect_w), int'(r.rect_h));
         end
         CMD_FULL: begin
            map_full  = 1'b1;
            map_count = 0;
         end
         CMD_RESET: begin
            map_full  = 1'b0;
            map_count = 0;
         end
         CMD_READ: begin
            if (int'(r.entry_index) < map_count) begin
               bx = map_x[r.entry_index[STEP_W-1:0]];
               by = map_y[r.entry_index[STEP_W-1:0]];
               bw = map_w[r.entry_index[STEP_W-1:0]];
               bh = map_h[r.entry_index[STEP_W-1:0]];
               hit = 1'b1;
            end
         end
         CMD_BBOX: begin
            if (map_full) begin
               bw = surf_limit(surf_w_reg);
               bh = surf_limit(surf_h_reg);
            end else if (map_count > 0) begin
               bx = map_x[0];
               by = map_y[0];
               x2 = map_x[0] + map_w[0];
               y2 = map_y[0] + map_h[0];
               for (int i = 1; i < map_count; i++) begin
                  bx = min_of(bx, map_x[i]);
                  by = min_of(by, map_y[i]);
                  x2 = max_of(x2, map_x[i] + map_w[i]);
                  y2 = max_of(y2, map_y[i] + map_h[i]);
               end
               bw = x2 - bx;
               bh = y2 - by;
            end
         end
         default: begin
         end
      endcase
      o.out_x        = bx[OUT_W-1:0];
      o.out_y        = by[OUT_W-1:0];
      o.out_w        = bw[OUT_W-1:0];
      o.out_h        = bh[OUT_W-1:0];
      o.entry_valid  = hit;
      o.region_count = map_count[OCNT_W-1:0];
      o.region_full  = map_full;
      o.region_empty = !map_full && map_count == 0;
      return o;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch on %s after %0d results: got %0d, expected %0d",
               field, results_seen, got, want);
      error_count++;
   endtask

   task automatic compare_result(rsp_type got, rsp_type want);
      if (got.out_x != want.out_x)
         report_mismatch("out_x", int'(got.out_x), int'(want.out_x));
      if (got.out_y != want.out_y)
         report_mismatch("out_y", int'(got.out_y), int'(want.out_y));
      if (got.out_w != want.out_w)
         report_mismatch("out_w", int'(got.out_w), int'(want.out_w));
      if (got.out_h != want.out_h)
         report_mismatch("out_h", int'(got.out_h), int'(want.out_h));
      if (got.entry_valid != want.entry_valid)
         report_mismatch("entry_valid", int'(got.entry_valid), int'(want.entry_valid));
      if (got.region_count != want.region_count)
         report_mismatch("region_count", int'(got.region_count), int'(want.region_count));
      if (got.region_full != want.region_full)
         report_mismatch("region_full", int'(got.region_full), int'(want.region_full));
      if (got.region_empty != want.region_empty)
         report_mismatch("region_empty", int'(got.region_empty), int'(want.region_empty));
   endtask

   // Both channels are observed at the rising edge. A result is checked
   // before a new request is predicted; no request can produce its result
   // in the same cycle it is transferred.
   always @(posedge clock) begin
      rsp_type         want;
      hand_answer_type hand;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_rsp.size() == 0) begin
               $display("unexpected result transfer with nothing outstanding");
               error_count++;
            end else begin
               compare_result(rsp_data, pending_rsp.pop_front());
            end
         end
         if (req_valid && !req_stall) begin
            want = damage_result(req_data);
            hand = hand_answers.pop_front();
            pending_rsp.push_back(hand.typed ? hand.answer : want);
         end
      end
   end

   // The result side stalls in random bursts while idling is enabled.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Presents one request and holds it until the block takes it. The valid
   // line is only touched once per falling edge.
   task automatic send_request(req_type r, bit typed, rsp_type answer);
      hand_answer_type hand;
      hand.typed  = typed;
      hand.answer = answer;
      hand_answers.push_back(hand);
      case (r.command)
         CMD_ADD:  adds_sent++;
         CMD_READ: reads_sent++;
         CMD_BBOX: boxes_sent++;
         default: begin
         end
      endcase
      @(negedge clock);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Drops valid, waits for every outstanding result and lets the block
   // finish any add that produced nothing visible yet.
   task automatic drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_surface(logic index, logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == REG_SURF_W) surf_w_reg = value;
      else surf_h_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type make_req(logic [2:0] cmd, int x, int y, int w, int h,
                                        int index);
      req_type r;
      r.command     = cmd;
      r.rect_x      = x[IN_W-1:0];
      r.rect_y      = y[IN_W-1:0];
      r.rect_w      = w[IN_W-1:0];
      r.rect_h      = h[IN_W-1:0];
      r.entry_index = index[IDX_IN_W-1:0];
      return r;
   endfunction

   function automatic rsp_type make_rsp(int x, int y, int w, int h, int hit, int count,
                                        int full, int empty);
      rsp_type o;
      o.out_x        = x[OUT_W-1:0];
      o.out_y        = y[OUT_W-1:0];
      o.out_w        = w[OUT_W-1:0];
      o.out_h        = h[OUT_W-1:0];
      o.entry_valid  = hit[0];
      o.region_count = count[OCNT_W-1:0];
      o.region_full  = full[0];
      o.region_empty = empty[0];
      return o;
   endfunction

   function automatic stim_row_type row(req_type r, int typed = 0,
                                        rsp_type answer = '0);
      stim_row_type s;
      s.req    = r;
      s.typed  = typed[0];
      s.answer = answer;
      return s;
   endfunction

   // Random traffic. Most adds are small rectangles scattered over the
   // surface, so the map fills up and overflows now and then; some are
   // near neighbors that should merge, and the rest use raw 16-bit values.
   function automatic req_type random_req();
      int sw;
      int sh;
      int pick;
      int x;
      int y;
      sw = surf_limit(surf_w_reg);
      sh = surf_limit(surf_h_reg);
      pick = $urandom_range(0, 199);
      if (pick < 110) begin
         x = $urandom_range(0, sw + 16) - 8;
         y = $urandom_range(0, sh + 16) - 8;
         return make_req(CMD_ADD, x, y, $urandom_range(0, 48) - 2,
                         $urandom_range(0, 48) - 2, $urandom);
      end else if (pick < 125) begin
         x = (map_count > 0) ? map_x[0] + $urandom_range(0, 14) - 7 : 0;
         y = (map_count > 0) ? map_y[0] + $urandom_range(0, 14) - 7 : 0;
         return make_req(CMD_ADD, x, y, $urandom_range(1, 300), $urandom_range(1, 300),
                         $urandom);
      end else if (pick < 140) begin
         return make_req(CMD_ADD, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 168) begin
         return make_req(CMD_READ, $urandom, $urandom, $urandom, $urandom,
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, MAX_RECTS));
      end else if (pick < 190) begin
         return make_req(CMD_BBOX, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 193) begin
         return make_req(CMD_RESET, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 195) begin
         return make_req(CMD_FULL, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      return make_req(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), $urandom, $urandom,
                      $urandom, $urandom, $urandom);
   endfunction

   initial begin
      stim_row_type directed [$];
      int           phase_w [RANDOM_PHASES];
      int           phase_h [RANDOM_PHASES];

      phase_w = '{640, 8192, 16383, 0, 3, 1920};
      phase_h = '{480, 8192, 16383, 1080, 2, 1080};

      error_count    = 0;
      adds_sent      = 0;
      reads_sent     = 0;
      boxes_sent     = 0;
      overflow_count = 0;
      results_seen   = 0;
      idle_enable    = 1'b1;
      map_count      = 0;
      map_full       = 1'b0;
      surf_w_reg     = 14'd1920;
      surf_h_reg     = 14'd1080;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = REG_SURF_W;
      csr_data  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, run with the surface size left at its reset value.
      // Empty map, unused command codes and an out-of-range read come first.
      directed.push_back(row(make_req(CMD_BBOX, 0, 0, 0, 0, 0), 1,
                             make_rsp(0, 0, 0, 0, 0, 0, 0, 1)));
      directed.push_back(row(make_req(CMD_READ, 0, 0, 0, 0, 0), 1,
                             make_rsp(0, 0, 0, 0, 0, 0, 0, 1)));
      directed.push_back(row(make_req(CMD_SPARE_LO, 5, 5, 5, 5, 1), 1,
                             make_rsp(0, 0, 0, 0, 0, 0, 0, 1)));
      directed.push_back(row(make_req(CMD_SPARE_HI, -1, -1, -1, -1, 63), 1,
                             make_rsp(0, 0, 0, 0, 0, 0, 0, 1)));
      // A rectangle clamped away entirely from the top-left corner.
      directed.push_back(row(make_req(CMD_ADD, -32768, -32768, 32767, 32767, 0)));
      // The largest rectangle clamps down to the whole surface.
      directed.push_back(row(make_req(CMD_ADD, 0, 0, 32767, 32767, 0)));
      directed.push_back(row(make_req(CMD_READ, 0, 0, 0, 0, 0), 1,
                             make_rsp(0, 0, 1920, 1080, 1, 1, 0, 0)));
      directed.push_back(row(make_req(CMD_READ, 0, 0, 0, 0, 63), 1,
                             make_rsp(0, 0, 0, 0, 0, 1, 0, 0)));
      // Starting past the surface, zero size and negative size are dropped.
      directed.push_back(row(make_req(CMD_ADD, 32767, 32767, 10, 10, 0)));
      directed.push_back(row(make_req(CMD_ADD, 100, 100, 0, 5, 0)));
      directed.push_back(row(make_req(CMD_ADD, 100, 100, -5, -32768, 0)));
      directed.push_back(row(make_req(CMD_RESET, 0, 0, 0, 0, 0), 1,
                             make_rsp(0, 0, 0, 0, 0, 0, 0, 1)));
      // A corner within the merge distance, a far one and a side neighbor.
      directed.push_back(row(make_req(CMD_ADD, 10, 10, 20, 20, 0)));
      directed.push_back(row(make_req(CMD_ADD, 12, 12, 4, 4, 0)));
      directed.push_back(row(make_req(CMD_ADD, 500, 500, 10, 10, 0)));
      directed.push_back(row(make_req(CMD_ADD, 40, 10, 20, 20, 0)));
      directed.push_back(row(make_req(CMD_ADD, 5, 5, 2000, 2, 0)));
      directed.push_back(row(make_req(CMD_BBOX, 0, 0, 0, 0, 0)));
      directed.push_back(row(make_req(CMD_READ, 0, 0, 0, 0, 1)));
      // Full-screen mode: adds are ignored and the box is the whole surface.
      directed.push_back(row(make_req(CMD_FULL, 0, 0, 0, 0, 0), 1,
                             make_rsp(0, 0, 0, 0, 0, 0, 1, 0)));
      directed.push_back(row(make_req(CMD_ADD, 1, 1, 8, 8, 0)));
      directed.push_back(row(make_req(CMD_BBOX, 0, 0, 0, 0, 0), 1,
                             make_rsp(0, 0, 1920, 1080, 0, 0, 1, 0)));
      directed.push_back(row(make_req(CMD_RESET, -1, -1, -1, -1, 63), 1,
                             make_rsp(0, 0, 0, 0, 0, 0, 0, 1)));
      directed.push_back(row(make_req(CMD_ADD, -1, -1, -1, -1, 63)));
      directed.push_back(row(make_req(CMD_READ, 0, 0, 0, 0, 0)));

      foreach (directed[i]) send_request(directed[i].req, directed[i].typed,
                                         directed[i].answer);

      // Random phases, each under its own surface size. The sender stops and
      // waits for the block to drain before every register write.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_block();
         write_surface(REG_SURF_W, CFG_W'(phase_w[p]));
         write_surface(REG_SURF_H, CFG_W'(phase_h[p]));
         if (p == RANDOM_PHASES - 1) idle_enable = 1'b0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_request(random_req(), 1'b0, '0);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d adds, %0d reads, %0d bounding boxes over %0d surface sizes",
               adds_sent, reads_sent, boxes_sent, RANDOM_PHASES);
      $display("map overflowed into full-screen mode %0d times, %0d results checked",
               overflow_count, results_seen);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog for a block that stops answering.
   initial begin
      #16000000;
      $display("timeout with %0d results outstanding", pending_rsp.size());
      $display("FAILURE");
      $finish;
   end

endmodule
